>>> rtl/gpc_pkg.sv
// Shared types, constants and register codes for the gait phase P controller.
`timescale 1ns / 1ps
`default_nettype none

package gpc_pkg;

    // Default geometry
    localparam int NUM_JOINTS_DEF = 12;
    localparam int NUM_PHASES_DEF = 4;

    // Fixed field widths
    localparam int ANGLE_BITS     = 16;
    localparam int JOINT_BITS     = 4;
    localparam int LPHASE_BITS    = 2;
    localparam int GAIN_BITS      = 16;
    localparam int THRESH_BITS    = 15;
    localparam int VEL_BITS       = 24;
    localparam int NUM_GAINS      = 4;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    // Velocity saturation limits (Q12)
    localparam int VEL_MAX = 8388607;
    localparam int VEL_MIN = -8388608;

    // Register reset values
    localparam logic [GAIN_BITS-1:0]   GAIN_RESET   = 16'd256;
    localparam logic [THRESH_BITS-1:0] THRESH_RESET = 15'd179;

    // Register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GAIN0     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GAIN1     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GAIN2     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GAIN3     = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD = 3'd4;

    // Request kind
    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_LOAD   = 1'b1
    } kind_t;

    // Incoming request: angle sample or target load
    typedef struct packed {
        kind_t                         kind;
        logic [JOINT_BITS-1:0]         joint;
        logic [LPHASE_BITS-1:0]        load_phase;
        logic signed [ANGLE_BITS-1:0]  angle;
    } sample_req_t;

    // Outgoing velocity command
    typedef struct packed {
        logic [JOINT_BITS-1:0]         out_joint;
        logic signed [VEL_BITS-1:0]    velocity;
        logic [LPHASE_BITS-1:0]        phase_used;
        logic                          joint_settled;
        logic                          phase_advanced;
    } cmd_req_t;

    // Configuration register bank
    typedef struct packed {
        logic [NUM_GAINS-1:0][GAIN_BITS-1:0] gain;
        logic [THRESH_BITS-1:0]              threshold;
    } cfg_t;

endpackage

`default_nettype wire

>>> rtl/gpc_cfg_regs.sv
// Configuration registers: per-phase gains and the settle threshold.
`timescale 1ns / 1ps
`default_nettype none

module gpc_cfg_regs
    import gpc_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      wr_en,
    input  wire logic [CFG_INDEX_BITS-1:0] index,
    input  wire logic [CFG_DATA_BITS-1:0]  data,
    output cfg_t                           cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Register write decode; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (index)
                CFG_GAIN0:     cfg_next.gain[0]   = data;
                CFG_GAIN1:     cfg_next.gain[1]   = data;
                CFG_GAIN2:     cfg_next.gain[2]   = data;
                CFG_GAIN3:     cfg_next.gain[3]   = data;
                CFG_THRESHOLD: cfg_next.threshold = data[THRESH_BITS-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain      <= {NUM_GAINS{GAIN_RESET}};
            cfg_reg.threshold <= THRESH_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> rtl/gpc_target_mem.sv
// Target angle memory: one row per joint holding the target of every phase.
`timescale 1ns / 1ps
`default_nettype none

module gpc_target_mem
    import gpc_pkg::*;
#(
    parameter int NUM_JOINTS = NUM_JOINTS_DEF,
    parameter int NUM_PHASES = NUM_PHASES_DEF,
    localparam int JW  = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1,
    localparam int PHW = (NUM_PHASES > 1) ? $clog2(NUM_PHASES) : 1
)
(
    input  wire logic                                  clk,
    input  wire logic                                  wr_en,
    input  wire logic [JW-1:0]                         wr_addr,
    input  wire logic [PHW-1:0]                        wr_lane,
    input  wire logic [ANGLE_BITS-1:0]                 wr_data,
    input  wire logic                                  rd_en,
    input  wire logic [JW-1:0]                         rd_addr,
    output logic [NUM_PHASES-1:0][ANGLE_BITS-1:0]      rd_row
);

    logic [NUM_PHASES-1:0][ANGLE_BITS-1:0] mem [NUM_JOINTS];
    logic [NUM_PHASES-1:0][ANGLE_BITS-1:0] rd_row_reg;

    // Lane write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr][wr_lane] <= wr_data;
        end
    end

    // Registered row read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_row_reg <= mem[rd_addr];
        end
    end

    assign rd_row = rd_row_reg;

endmodule

`default_nettype wire

>>> rtl/gpc_servo_stage.sv
// Error, gain multiply, saturation, settle tracking, phase stepping and result register.
`timescale 1ns / 1ps
`default_nettype none

module gpc_servo_stage
    import gpc_pkg::*;
#(
    parameter int NUM_JOINTS = NUM_JOINTS_DEF,
    parameter int NUM_PHASES = NUM_PHASES_DEF
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire cfg_t                                  cfg,
    input  wire logic                                  s1_valid,
    input  wire logic [JOINT_BITS-1:0]                 s1_joint,
    input  wire logic signed [ANGLE_BITS-1:0]          s1_angle,
    input  wire logic [NUM_PHASES-1:0][ANGLE_BITS-1:0] s1_row,
    input  wire logic                                  cmd_stall,
    output logic                                       s1_advance,
    output logic                                       cmd_valid,
    output cmd_req_t                                   cmd_req
);

    localparam int PHW  = (NUM_PHASES > 1) ? $clog2(NUM_PHASES) : 1;
    localparam int CW   = $clog2(NUM_JOINTS + 1);
    localparam int EW   = ANGLE_BITS + 1;
    localparam int PRW  = EW + GAIN_BITS;
    localparam int SW   = PRW - 8;
    localparam int CMPW = (SW > VEL_BITS) ? SW : VEL_BITS + 1;
    localparam logic signed [CMPW-1:0] VMAX = CMPW'(VEL_MAX);
    localparam logic signed [CMPW-1:0] VMIN = CMPW'(VEL_MIN);

    logic [PHW-1:0]              phase_reg, phase_next, phase_inc;
    logic [CW-1:0]               count_reg, count_next, count_base, count_inc;
    logic                        cmd_valid_reg, cmd_valid_next;
    cmd_req_t                    cmd_req_reg, cmd_req_next;

    logic [31:0]                 phase_ext, joint_ext;
    logic signed [ANGLE_BITS-1:0] target;
    logic signed [EW-1:0]        err;
    logic [EW-1:0]               mag;
    logic                        settled, last_joint, advanced, take;
    logic signed [GAIN_BITS-1:0] gain;
    logic signed [PRW-1:0]       prod;
    logic signed [SW-1:0]        shifted;
    logic signed [CMPW-1:0]      vel_wide;
    logic [VEL_BITS-1:0]         vel;

    // Error and settle check
    always_comb
    begin
        phase_ext = 32'(phase_reg);
        joint_ext = 32'(s1_joint);
        target    = $signed(s1_row[phase_reg]);
        err       = {target[ANGLE_BITS-1], target} - {s1_angle[ANGLE_BITS-1], s1_angle};
        mag       = err[EW-1] ? -err : err;
        settled   = mag < EW'(cfg.threshold);
    end

    // Gain multiply, floor to Q12, saturate
    always_comb
    begin
        gain     = $signed(cfg.gain[phase_ext[1:0]]);
        prod     = gain * err;
        shifted  = $signed(prod[PRW-1:8]);
        vel_wide = CMPW'(shifted);
        if (vel_wide > VMAX)
            vel = VMAX[VEL_BITS-1:0];
        else if (vel_wide < VMIN)
            vel = VMIN[VEL_BITS-1:0];
        else
            vel = vel_wide[VEL_BITS-1:0];
    end

    // Sweep settle count and phase stepping
    always_comb
    begin
        count_base = (joint_ext == 32'd0) ? '0 : count_reg;
        count_inc  = (settled && (count_base < CW'(NUM_JOINTS))) ? count_base + 1'b1
                                                                  : count_base;
        last_joint = (joint_ext == 32'(NUM_JOINTS - 1));
        advanced   = last_joint && (count_inc >= CW'(NUM_JOINTS));
        phase_inc  = (phase_reg == PHW'(NUM_PHASES - 1)) ? '0 : phase_reg + 1'b1;
    end

    // Handshake and next state
    always_comb
    begin
        s1_advance = !cmd_valid_reg || !cmd_stall;
        take       = s1_valid && s1_advance;

        cmd_valid_next = s1_advance ? s1_valid : cmd_valid_reg;
        count_next     = take ? (last_joint ? '0 : count_inc) : count_reg;
        phase_next     = (take && advanced) ? phase_inc : phase_reg;

        cmd_req_next.out_joint      = s1_joint;
        cmd_req_next.velocity       = vel;
        cmd_req_next.phase_used     = phase_ext[LPHASE_BITS-1:0];
        cmd_req_next.joint_settled  = settled;
        cmd_req_next.phase_advanced = advanced;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            count_reg     <= '0;
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_req_reg <= cmd_req_next;
        end
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd_req   = cmd_req_reg;

endmodule

`default_nettype wire

>>> rtl/gait_phase_p_controller_unit.sv
// Top level of the gait phase proportional joint controller.
// Pipeline: an accepted request passes the input/memory stage, then the result register.
// Throughput: one request per cycle while sample_stall is low; loads and out-of-range requests give no command.
// The target memory write and row read share the acceptance edge, so a load is seen next cycle.
// Reset: gait phase and settle count cleared, gains 256, threshold 179; targets undefined.
`timescale 1ns / 1ps
`default_nettype none

module gait_phase_p_controller_unit
    import gpc_pkg::*;
#(
    parameter int NUM_JOINTS = NUM_JOINTS_DEF,
    parameter int NUM_PHASES = NUM_PHASES_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      sample_valid,
    output logic                           sample_stall,
    input  wire sample_req_t               sample_req,
    output logic                           cmd_valid,
    input  wire logic                      cmd_stall,
    output cmd_req_t                       cmd_req,
    input  wire logic                      cfg_wr_en,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int JW  = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
    localparam int PHW = (NUM_PHASES > 1) ? $clog2(NUM_PHASES) : 1;

    cfg_t                                  cfg;
    logic                                  s1_valid_reg, s1_valid_next;
    sample_req_t                           s1_item_reg;
    logic [NUM_PHASES-1:0][ANGLE_BITS-1:0] s1_row;
    logic                                  s1_advance;
    logic                                  accept, is_sample, is_load;
    logic [31:0]                           joint_ext, lphase_ext;

    // Request decode
    always_comb
    begin
        sample_stall = s1_valid_reg && !s1_advance;
        accept       = sample_valid && !sample_stall;
        joint_ext    = 32'(sample_req.joint);
        lphase_ext   = 32'(sample_req.load_phase);
        is_sample    = accept && (joint_ext < NUM_JOINTS) && (sample_req.kind == KIND_SAMPLE);
        is_load      = accept && (joint_ext < NUM_JOINTS) && (lphase_ext < NUM_PHASES)
                       && (sample_req.kind == KIND_LOAD);
        s1_valid_next = is_sample ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_reg);
    end

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_sample)
        begin
            s1_item_reg <= sample_req;
        end
    end

    gpc_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (cfg_wr_en),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    gpc_target_mem #(
        .NUM_JOINTS (NUM_JOINTS),
        .NUM_PHASES (NUM_PHASES)
    ) u_target_mem (
        .clk     (clk),
        .wr_en   (is_load),
        .wr_addr (joint_ext[JW-1:0]),
        .wr_lane (lphase_ext[PHW-1:0]),
        .wr_data (sample_req.angle),
        .rd_en   (is_sample),
        .rd_addr (joint_ext[JW-1:0]),
        .rd_row  (s1_row)
    );

    gpc_servo_stage #(
        .NUM_JOINTS (NUM_JOINTS),
        .NUM_PHASES (NUM_PHASES)
    ) u_servo_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .s1_valid   (s1_valid_reg),
        .s1_joint   (s1_item_reg.joint),
        .s1_angle   (s1_item_reg.angle),
        .s1_row     (s1_row),
        .cmd_stall  (cmd_stall),
        .s1_advance (s1_advance),
        .cmd_valid  (cmd_valid),
        .cmd_req    (cmd_req)
    );

endmodule

`default_nettype wire

>>> rtl/gpc_checker.sv
// Port-level checks for the gait phase controller, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module gpc_checker
    import gpc_pkg::*;
#(
    parameter int NUM_JOINTS = NUM_JOINTS_DEF
)
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        sample_stall,
    input wire logic        cmd_valid,
    input wire logic        cmd_stall,
    input wire cmd_req_t    cmd_req
);

    // A stalled command holds
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd_req))
        else $error("stalled command changed or dropped");

    // A phase step only comes on the last joint of a sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_req.phase_advanced |->
            (32'(cmd_req.out_joint) == NUM_JOINTS - 1))
        else $error("phase advanced on a joint that cannot close a sweep");

    // Commands only name joints that exist
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> (32'(cmd_req.out_joint) < NUM_JOINTS))
        else $error("command for out-of-range joint");

    // Leaving reset, the pipeline is empty
    assert property (@(posedge clk)
        $rose(rst_n) |-> !cmd_valid && !sample_stall)
        else $error("pipeline not empty after reset");

endmodule

bind gait_phase_p_controller_unit gpc_checker #(
    .NUM_JOINTS (NUM_JOINTS)
) u_gpc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_stall (sample_stall),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .cmd_req      (cmd_req)
);

`default_nettype wire

>>> test/tb_gait_phase_p_controller_unit.sv
// Self-checking testbench for the gait phase proportional joint controller.
`timescale 1ns / 1ps

module tb_gait_phase_p_controller_unit;
    import gpc_pkg::*;

    localparam int NJ         = NUM_JOINTS_DEF;
    localparam int NPH        = NUM_PHASES_DEF;
    localparam int STIM_VIEW  = 0;   // controller state as the stimulus plans it
    localparam int DUT_VIEW   = 1;   // controller state as requests are accepted
    localparam int CYCLE_CAP  = 400000;
    localparam int PRINT_CAP  = 60;
    localparam int EPOCHS     = 6;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_LAST  = 3'd7;

    // One planned request plus an optional hold until all commands are back
    typedef struct {
        sample_req_t rq;
        bit          drain_first;
    } planned_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        sample_valid = 1'b0;
    logic        sample_stall;
    sample_req_t sample_req = '0;
    logic        cmd_valid;
    logic        cmd_stall = 1'b0;
    cmd_req_t    cmd_req;
    logic        cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    // Controller state, one copy per view
    logic signed [ANGLE_BITS-1:0] tgt_tab [2][NPH*NJ];
    logic signed [GAIN_BITS-1:0]  gain_reg [2][NUM_GAINS];
    logic [THRESH_BITS-1:0]       thr_reg [2];
    logic [LPHASE_BITS-1:0]       gait_ph [2];
    int                           settle_cnt [2];

    planned_req_t sample_plan_q [$];
    cmd_req_t     cmd_expect_q [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int issued_cnt = 0;
    int got_cnt = 0;
    int advance_cnt = 0;
    int planned_cnt = 0;
    int planned_all = 0;
    int mismatch_cnt = 0;
    int cycle_cnt = 0;

    cmd_req_t     drv_cmd;
    bit           drv_made;
    planned_req_t drv_item;
    cmd_req_t     mon_exp;

    gait_phase_p_controller_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_req   (sample_req),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .cmd_req      (cmd_req),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Clock
    always #5 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what, input longint want, input longint seen);
        if (mismatch_cnt < PRINT_CAP)
            $display("[%0t] mismatch %s: expected %0d, got %0d", $realtime, what, want, seen);
        mismatch_cnt++;
    endtask

    // Velocity command for one request; updates the chosen view's state
    function automatic bit predict_cmd(input int v, input sample_req_t rq, output cmd_req_t c);
        int     tgt;
        int     err;
        int     mag;
        longint vel;
        bit     settled;
        bit     advanced;
        logic [LPHASE_BITS-1:0] ph;
        c = '0;
        if (int'(rq.joint) >= NJ)
            return 1'b0;
        if (rq.kind == KIND_LOAD)
        begin
            if (int'(rq.load_phase) < NPH)
                tgt_tab[v][int'(rq.load_phase) * NJ + int'(rq.joint)] = rq.angle;
            return 1'b0;
        end
        ph = gait_ph[v];
        tgt = tgt_tab[v][int'(ph) * NJ + int'(rq.joint)];
        err = tgt - int'(rq.angle);
        mag = (err < 0) ? -err : err;
        settled = mag < int'(thr_reg[v]);
        // Q.20 product floored to Q12, then clipped to 24 bits
        vel = (longint'(gain_reg[v][ph]) * longint'(err)) >>> 8;
        if (vel > VEL_MAX)
            vel = VEL_MAX;
        if (vel < VEL_MIN)
            vel = VEL_MIN;
        advanced = 1'b0;
        if (rq.joint == 0)
            settle_cnt[v] = 0;
        if (settled && settle_cnt[v] < NJ)
            settle_cnt[v]++;
        if (int'(rq.joint) == NJ - 1)
        begin
            if (settle_cnt[v] >= NJ)
            begin
                gait_ph[v] = LPHASE_BITS'((int'(ph) + 1) % NPH);
                advanced = 1'b1;
            end
            settle_cnt[v] = 0;
        end
        c.out_joint      = rq.joint;
        c.velocity       = VEL_BITS'(vel);
        c.phase_used     = ph;
        c.joint_settled  = settled;
        c.phase_advanced = advanced;
        return 1'b1;
    endfunction

    function automatic void apply_reg(input int v, input logic [CFG_INDEX_BITS-1:0] idx,
                                      input logic [CFG_DATA_BITS-1:0] val);
        case (idx) inside
            CFG_GAIN0, CFG_GAIN1, CFG_GAIN2, CFG_GAIN3: gain_reg[v][idx[1:0]] = val;
            CFG_THRESHOLD:                              thr_reg[v] = val[THRESH_BITS-1:0];
            default:                                    ;
        endcase
    endfunction

    // Request driver: presents planned requests, tracks accepted ones
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            sample_req   <= '0;
        end
        else
        begin
            drv_made = 1'b0;
            if (sample_valid && !sample_stall)
            begin
                drv_made = predict_cmd(DUT_VIEW, sample_req, drv_cmd);
                if (drv_made)
                begin
                    cmd_expect_q = {cmd_expect_q, drv_cmd};
                    issued_cnt <= issued_cnt + 1;
                end
            end
            if (!sample_valid || !sample_stall)
            begin
                if (sample_plan_q.size() != 0 &&
                    !(sample_plan_q[0].drain_first && (drv_made || issued_cnt != got_cnt)) &&
                    $urandom_range(0, 99) >= send_idle_pct)
                begin
                    drv_item = sample_plan_q.pop_front();
                    sample_req   <= drv_item.rq;
                    sample_valid <= 1'b1;
                end
                else
                begin
                    sample_valid <= 1'b0;
                end
            end
        end
    end

    // Command monitor: random stall, field by field compare
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_stall <= 1'b0;
        end
        else
        begin
            if (cmd_valid && !cmd_stall)
            begin
                got_cnt <= got_cnt + 1;
                if (cmd_expect_q.size() == 0)
                begin
                    flag_mismatch("unexpected command, joint", -1, cmd_req.out_joint);
                end
                else
                begin
                    mon_exp = cmd_expect_q.pop_front();
                    if (cmd_req.out_joint !== mon_exp.out_joint)
                        flag_mismatch("out_joint", mon_exp.out_joint, cmd_req.out_joint);
                    if (cmd_req.velocity !== mon_exp.velocity)
                        flag_mismatch("velocity", mon_exp.velocity, cmd_req.velocity);
                    if (cmd_req.phase_used !== mon_exp.phase_used)
                        flag_mismatch("phase_used", mon_exp.phase_used, cmd_req.phase_used);
                    if (cmd_req.joint_settled !== mon_exp.joint_settled)
                        flag_mismatch("joint_settled", mon_exp.joint_settled,
                                      cmd_req.joint_settled);
                    if (cmd_req.phase_advanced !== mon_exp.phase_advanced)
                        flag_mismatch("phase_advanced", mon_exp.phase_advanced,
                                      cmd_req.phase_advanced);
                    if (mon_exp.phase_advanced)
                        advance_cnt <= advance_cnt + 1;
                end
            end
            cmd_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Queue one request and step the planning view with it
    task automatic plan_item(input kind_t k, input int j, input int lp, input int ang,
                             input bit drain);
        planned_req_t item;
        cmd_req_t     unused;
        item.rq.kind       = k;
        item.rq.joint      = JOINT_BITS'(j);
        item.rq.load_phase = LPHASE_BITS'(lp);
        item.rq.angle      = ANGLE_BITS'(ang);
        item.drain_first   = drain || ($urandom_range(0, 299) == 0);
        void'(predict_cmd(STIM_VIEW, item.rq, unused));
        sample_plan_q = {sample_plan_q, item};
        planned_all++;
        if (j < NJ)
            planned_cnt++;
    endtask

    // Angle for joint j in the planned phase, inside or around the settle band
    function automatic int settle_angle(input int j, input bit want);
        int tgt;
        int t;
        int delta;
        int a;
        tgt = tgt_tab[STIM_VIEW][int'(gait_ph[STIM_VIEW]) * NJ + j];
        t = int'(thr_reg[STIM_VIEW]);
        if (want && t > 0)
        begin
            delta = int'($urandom_range(0, 2 * (t - 1))) - (t - 1);
        end
        else
        begin
            case ($urandom_range(0, 3))
                0:       delta = t;
                1:       delta = -t;
                default: delta = int'($urandom_range(0, 65535)) - 32768;
            endcase
        end
        a = tgt - delta;
        if (a > 32767)
            a = 32767;
        if (a < -32768)
            a = -32768;
        return a;
    endfunction

    // Load all target entries in shuffled order
    task automatic fill_targets();
        int order [NPH*NJ];
        int i;
        int k;
        int tmp;
        int val;
        for (i = 0; i < NPH * NJ; i++)
            order[i] = i;
        for (i = NPH * NJ - 1; i > 0; i--)
        begin
            k = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[k];
            order[k] = tmp;
        end
        for (i = 0; i < NPH * NJ; i++)
        begin
            case ($urandom_range(0, 7))
                0:       val = 32767;
                1:       val = -32768;
                default: val = int'($urandom_range(0, 65535)) - 32768;
            endcase
            plan_item(KIND_LOAD, order[i] % NJ, order[i] / NJ, val, 1'b0);
        end
    endtask

    // One sweep 0..11; a broken one stops early, skips or repeats joints
    task automatic plan_sweep(input int settle_pct, input bit broken, input bit drain);
        int j;
        int stop_at;
        int skip_j;
        bit first;
        stop_at = broken ? $urandom_range(0, NJ - 1) : NJ - 1;
        skip_j  = (broken && $urandom_range(0, 1)) ? $urandom_range(1, NJ - 1) : -1;
        first   = drain;
        for (j = 0; j <= stop_at; j++)
        begin
            if (j != skip_j)
            begin
                plan_item(KIND_SAMPLE, j, $urandom_range(0, 3),
                          settle_angle(j, $urandom_range(0, 99) < settle_pct), first);
                first = 1'b0;
                if (broken && $urandom_range(0, 5) == 0)
                    plan_item(KIND_SAMPLE, j, $urandom_range(0, 3),
                              settle_angle(j, $urandom_range(0, 99) < settle_pct), 1'b0);
            end
        end
    endtask

    // A few unconstrained requests, out of range joints included
    task automatic plan_noise();
        int n;
        for (n = $urandom_range(1, 4); n > 0; n--)
            plan_item($urandom_range(0, 1) ? KIND_LOAD : KIND_SAMPLE, $urandom_range(0, 15),
                      $urandom_range(0, 3), int'($urandom_range(0, 65535)) - 32768, 1'b0);
    endtask

    task automatic run_epoch(input int quota);
        int goal;
        int r;
        int iter;
        goal = planned_cnt + quota;
        iter = 0;
        while (planned_cnt < goal)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                plan_sweep(97, 1'b0, iter == 5);
            else if (r < 70)
                plan_sweep(50, 1'b0, 1'b0);
            else if (r < 82)
                plan_sweep(85, 1'b1, 1'b0);
            else
                plan_noise();
            iter++;
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        apply_reg(STIM_VIEW, idx, val);
        apply_reg(DUT_VIEW, idx, val);
    endtask

    // Register settings per epoch
    task automatic set_registers(input int ep);
        logic [CFG_INDEX_BITS-1:0] idx;
        case (ep)
            1:
            begin
                write_reg(CFG_GAIN0, 16'h7FFF);
                write_reg(CFG_GAIN1, 16'h8000);
                write_reg(CFG_GAIN2, 16'h0000);
                write_reg(CFG_GAIN3, 16'h0001);
                write_reg(CFG_THRESHOLD, 16'h7FFF);
            end
            2:
            begin
                write_reg(CFG_GAIN0, CFG_DATA_BITS'($urandom));
                write_reg(CFG_GAIN1, CFG_DATA_BITS'($urandom));
                write_reg(CFG_GAIN2, CFG_DATA_BITS'($urandom));
                write_reg(CFG_GAIN3, CFG_DATA_BITS'($urandom));
                write_reg(CFG_THRESHOLD, 16'h0000);
            end
            3:
            begin
                write_reg(CFG_GAIN0, 16'hFFFF);
                write_reg(CFG_GAIN1, 16'h0100);
                write_reg(CFG_GAIN2, 16'h0200);
                write_reg(CFG_GAIN3, 16'hFF00);
                // top data bit falls outside the threshold register
                write_reg(CFG_THRESHOLD, 16'h8001);
                for (idx = CFG_SPARE_FIRST; idx != CFG_SPARE_FIRST - 1; idx++)
                begin
                    write_reg(idx, CFG_DATA_BITS'($urandom));
                    if (idx == CFG_SPARE_LAST)
                        break;
                end
            end
            4:
            begin
                write_reg(CFG_GAIN0, CFG_DATA_BITS'($urandom));
                write_reg(CFG_GAIN1, CFG_DATA_BITS'($urandom));
                write_reg(CFG_GAIN2, CFG_DATA_BITS'($urandom));
                write_reg(CFG_GAIN3, CFG_DATA_BITS'($urandom));
                write_reg(CFG_THRESHOLD, CFG_DATA_BITS'($urandom_range(50, 3000)));
            end
            default:
            begin
                write_reg(CFG_GAIN0, GAIN_RESET);
                write_reg(CFG_GAIN1, GAIN_RESET);
                write_reg(CFG_GAIN2, GAIN_RESET);
                write_reg(CFG_GAIN3, GAIN_RESET);
                write_reg(CFG_THRESHOLD, CFG_DATA_BITS'(THRESH_RESET));
            end
        endcase
    endtask

    // Block idle: nothing queued, nothing owed, pipeline flushed
    task automatic wait_drained();
        @(negedge clk);
        while (sample_plan_q.size() != 0 || sample_valid || issued_cnt != got_cnt)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Stimulus sequence
    initial
    begin
        int v;
        int i;
        int ep;
        for (v = 0; v < 2; v++)
        begin
            for (i = 0; i < NUM_GAINS; i++)
                gain_reg[v][i] = GAIN_RESET;
            for (i = 0; i < NPH * NJ; i++)
                tgt_tab[v][i] = '0;
            thr_reg[v]    = THRESH_RESET;
            gait_ph[v]    = '0;
            settle_cnt[v] = 0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (ep = 0; ep < EPOCHS; ep++)
        begin
            if (ep > 0)
            begin
                wait_drained();
                set_registers(ep);
                @(negedge clk);
            end
            send_idle_pct  = (ep < 2) ? 30 : (ep < 4) ? 81 : 0;
            recv_stall_pct = (ep < 2) ? 81 : (ep < 4) ? 30 : 0;
            if (ep == 0)
            begin
                // directed: angle extremes, ignored joints, sweep restart, repeats
                plan_item(KIND_LOAD, 0, 0, 32767, 1'b0);
                plan_item(KIND_LOAD, 1, 0, -32768, 1'b0);
                plan_item(KIND_LOAD, 11, 0, 0, 1'b0);
                plan_item(KIND_LOAD, 5, 3, 1234, 1'b0);
                plan_item(KIND_LOAD, 15, 2, -1, 1'b0);
                plan_item(KIND_LOAD, 12, 0, 77, 1'b0);
                plan_item(KIND_SAMPLE, 0, 0, -32768, 1'b0);
                plan_item(KIND_SAMPLE, 1, 1, 32767, 1'b0);
                plan_item(KIND_SAMPLE, 0, 0, 32767, 1'b0);
                plan_item(KIND_SAMPLE, 0, 0, 32767 - 178, 1'b0);
                plan_item(KIND_SAMPLE, 1, 0, -32768 + 179, 1'b0);
                plan_item(KIND_SAMPLE, 12, 0, 0, 1'b0);
                plan_item(KIND_SAMPLE, 15, 3, -1, 1'b0);
                plan_item(KIND_SAMPLE, 11, 3, 0, 1'b0);
                plan_item(KIND_SAMPLE, 11, 3, 0, 1'b0);
                plan_item(KIND_SAMPLE, 1, 2, -32768, 1'b0);
                fill_targets();
            end
            if (ep == 3)
                fill_targets();
            run_epoch(300);
        end
        wait_drained();
        repeat (8) @(negedge clk);

        if (cmd_expect_q.size() != 0)
            flag_mismatch("commands never seen", cmd_expect_q.size(), 0);
        $display("%0d requests sent (%0d in range), %0d commands checked, %0d phase steps",
                 planned_all, planned_cnt, got_cnt, advance_cnt);
        $display("%0d register settings, both idle patterns and a back-to-back run",
                 EPOCHS);
        if (mismatch_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
